// ===== hw/rtl/pfc_pkg.sv =====
package pfc_pkg;

   localparam int Side    = 5;
   localparam int Cells   = Side * Side;
   localparam int Letters = 26;

   typedef logic [4:0] letter_type;
   typedef logic [4:0] cell_type;
   typedef logic [2:0] coord_type;

   localparam letter_type LETTER_I    = 5'd8;
   localparam letter_type LETTER_J    = 5'd9;
   localparam letter_type LETTER_X    = 5'd23;
   localparam letter_type LETTER_Z    = 5'd25;
   localparam letter_type LAST_LETTER = 5'(Letters - 1);
   localparam cell_type   NUM_CELLS   = 5'(Cells);
   localparam coord_type  LAST_COORD  = 3'(Side - 1);

   typedef enum logic [1:0] {
      CMD_KEY_LETTER,
      CMD_KEY_END,
      CMD_PLAIN_LETTER,
      CMD_PLAIN_END
   } command_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FILL,
      ST_CELL,
      ST_SQUARE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic take;
      logic fill;
      logic square_rd;
      logic load_out;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic starts_fill;
      logic pair_hit;
      logic fill_last;
      logic out_free;
   } dp_status_type;

   // row of a cell in the square
   function automatic coord_type cell_row(input cell_type p);
      coord_type r;
      if (p >= 5'(4 * Side))      r = 3'd4;
      else if (p >= 5'(3 * Side)) r = 3'd3;
      else if (p >= 5'(2 * Side)) r = 3'd2;
      else if (p >= 5'(Side))     r = 3'd1;
      else                        r = 3'd0;
      return r;
   endfunction

   // cell number from row and column
   function automatic cell_type cell_index(input coord_type r, input coord_type c);
      return 5'({r, 2'b00}) + 5'(r) + 5'(c);
   endfunction

   // column of a cell in the square
   function automatic coord_type cell_col(input cell_type p);
      cell_type base;
      base = cell_index(cell_row(p), 3'd0);
      return 3'(p - base);
   endfunction

   // step one place with wrap around the square side
   function automatic coord_type wrap_inc(input coord_type x);
      return (x == LAST_COORD) ? 3'd0 : 3'(x + 3'd1);
   endfunction

endpackage

// ===== hw/rtl/pfc_ctrl.sv =====
module pfc_ctrl import pfc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               if (status.starts_fill) begin
                  state_in = ST_FILL;
               end else if (status.pair_hit) begin
                  state_in = ST_CELL;
               end
            end
         end
         ST_FILL: begin
            cmd.fill = 1'b1;
            if (status.fill_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_CELL: begin
            cmd.square_rd = 1'b1;
            state_in      = ST_SQUARE;
         end
         ST_SQUARE: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hw/rtl/pfc_dp.sv =====
module pfc_dp import pfc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  command_type   req_command,
   input  letter_type    req_letter,
   input  ctrl_cmd_type  cmd,
   output dp_status_type status,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output letter_type    rsp_first,
   output letter_type    rsp_second,
   output logic          rsp_closes
);

   // square contents and letter positions
   letter_type square_mem [Cells];
   cell_type   cell_mem   [Letters];

   logic [Letters-1:0] used_ff, used_in;
   cell_type   next_cell_ff, next_cell_in;
   logic       key_ready_ff, key_ready_in;
   letter_type fill_cnt_ff, fill_cnt_in;
   letter_type prev_ff, prev_in;
   logic       has_prev_ff, has_prev_in;
   letter_type pend_ff, pend_in;
   logic       has_pend_ff, has_pend_in;

   cell_type   p1_ff, p2_ff;
   letter_type q1_ff, q2_ff;
   logic       closes_ff;

   logic       rsp_valid_ff, rsp_valid_in;
   letter_type rsp_first_ff, rsp_second_ff;
   logic       rsp_closes_ff;

   letter_type         letter_fold;
   logic               letter_ok;
   logic               rekey;
   logic               key_end_go;
   logic [Letters-1:0] used_base;
   cell_type           next_eff;
   letter_type         place_letter;
   logic               place_try;
   logic               place_go;
   logic               dup;
   letter_type         bogus;
   letter_type         pad;
   logic               plain_go;
   logic               end_go;
   logic               clear_text;
   letter_type         pair_first, pair_second;
   logic               lookup_go;

   coord_type r1, c1, r2, c2;
   cell_type  e1, e2;

   // fold j into i and qualify the letter
   assign letter_fold = (req_letter == LETTER_J) ? LETTER_I : req_letter;
   assign letter_ok   = (letter_fold <= LAST_LETTER);

   assign rekey      = cmd.take && (req_command == CMD_KEY_LETTER) && letter_ok && key_ready_ff;
   assign key_end_go = cmd.take && (req_command == CMD_KEY_END) && !key_ready_ff;
   assign plain_go   = cmd.take && (req_command == CMD_PLAIN_LETTER) && letter_ok && key_ready_ff;
   assign end_go     = cmd.take && (req_command == CMD_PLAIN_END) && key_ready_ff;

   // place one letter: from the key stream or from the fill counter
   always_comb begin
      used_base = rekey ? '0 : used_ff;
      next_eff  = rekey ? '0 : next_cell_ff;
      if (cmd.fill) begin
         place_letter = fill_cnt_ff;
         place_try    = (fill_cnt_ff != LETTER_J);
      end else begin
         place_letter = letter_fold;
         place_try    = cmd.take && (req_command == CMD_KEY_LETTER) && letter_ok;
      end
      place_go = place_try && !used_base[place_letter] && (next_eff < NUM_CELLS);
      used_in  = used_base;
      if (place_go) begin
         used_in[place_letter] = 1'b1;
      end
      next_cell_in = place_go ? 5'(next_eff + 5'd1) : next_eff;
   end

   // key state and fill counter
   always_comb begin
      key_ready_in = key_ready_ff;
      fill_cnt_in  = fill_cnt_ff;
      if (rekey) begin
         key_ready_in = 1'b0;
      end
      if (key_end_go) begin
         fill_cnt_in = '0;
      end else if (cmd.fill) begin
         fill_cnt_in = 5'(fill_cnt_ff + 5'd1);
         if (fill_cnt_ff == LAST_LETTER) begin
            key_ready_in = 1'b1;
         end
      end
   end

   assign clear_text = rekey || (cmd.fill && (fill_cnt_ff == LAST_LETTER)) || end_go;

   // form digraphs from the plaintext stream
   assign dup   = has_prev_ff && (prev_ff == letter_fold);
   assign bogus = (prev_ff == LETTER_X) ? LETTER_Z : LETTER_X;
   assign pad   = (pend_ff == LETTER_X) ? LETTER_Z : LETTER_X;

   always_comb begin
      prev_in     = prev_ff;
      has_prev_in = has_prev_ff;
      pend_in     = pend_ff;
      has_pend_in = has_pend_ff;
      pair_first  = pend_ff;
      pair_second = letter_fold;
      if (clear_text) begin
         prev_in     = '0;
         has_prev_in = 1'b0;
         pend_in     = '0;
         has_pend_in = 1'b0;
         if (end_go) begin
            pair_second = pad;
         end
      end else if (plain_go) begin
         prev_in     = letter_fold;
         has_prev_in = 1'b1;
         if (dup) begin
            if (has_pend_ff) begin
               pair_second = bogus;
               pend_in     = letter_fold;
               has_pend_in = 1'b1;
            end else begin
               pair_first  = bogus;
               has_pend_in = 1'b0;
            end
         end else if (has_pend_ff) begin
            has_pend_in = 1'b0;
         end else begin
            pend_in     = letter_fold;
            has_pend_in = 1'b1;
         end
      end
   end

   assign lookup_go = (plain_go && (dup || has_pend_ff)) || (end_go && has_pend_ff);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         next_cell_ff <= '0;
         key_ready_ff <= 1'b0;
         fill_cnt_ff  <= '0;
         prev_ff      <= '0;
         has_prev_ff  <= 1'b0;
         pend_ff      <= '0;
         has_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         next_cell_ff <= next_cell_in;
         key_ready_ff <= key_ready_in;
         fill_cnt_ff  <= fill_cnt_in;
         prev_ff      <= prev_in;
         has_prev_ff  <= has_prev_in;
         pend_ff      <= pend_in;
         has_pend_ff  <= has_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // write the square and the letter positions
   always_ff @(posedge clock) begin
      if (place_go) begin
         square_mem[next_eff]   <= place_letter;
         cell_mem[place_letter] <= next_eff;
      end
   end

   // look up the cells of both pair letters
   always_ff @(posedge clock) begin
      if (lookup_go) begin
         p1_ff     <= cell_mem[pair_first];
         p2_ff     <= cell_mem[pair_second];
         closes_ff <= end_go;
      end
   end

   // apply the row, column or rectangle rule
   always_comb begin
      r1 = cell_row(p1_ff);
      c1 = cell_col(p1_ff);
      r2 = cell_row(p2_ff);
      c2 = cell_col(p2_ff);
      if (r1 == r2) begin
         e1 = cell_index(r1, wrap_inc(c1));
         e2 = cell_index(r2, wrap_inc(c2));
      end else if (c1 == c2) begin
         e1 = cell_index(wrap_inc(r1), c1);
         e2 = cell_index(wrap_inc(r2), c2);
      end else begin
         e1 = cell_index(r1, c2);
         e2 = cell_index(r2, c1);
      end
   end

   // read the cipher letters
   always_ff @(posedge clock) begin
      if (cmd.square_rd) begin
         q1_ff <= square_mem[e1];
         q2_ff <= square_mem[e2];
      end
   end

   // output register
   assign rsp_valid_in = cmd.load_out ? 1'b1 : (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_first_ff  <= q1_ff;
         rsp_second_ff <= q2_ff;
         rsp_closes_ff <= closes_ff;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_first  = rsp_first_ff;
   assign rsp_second = rsp_second_ff;
   assign rsp_closes = rsp_closes_ff;

   // status toward the controller
   assign status.starts_fill = (req_command == CMD_KEY_END) && !key_ready_ff;
   assign status.pair_hit    = key_ready_ff &&
                               (((req_command == CMD_PLAIN_LETTER) && letter_ok &&
                                 (dup || has_pend_ff)) ||
                                ((req_command == CMD_PLAIN_END) && has_pend_ff));
   assign status.fill_last   = (fill_cnt_ff == LAST_LETTER);
   assign status.out_free    = !rsp_valid_ff || rsp_ready;

endmodule

// ===== hw/rtl/playfair_digraph_cipher.sv =====
// Playfair encryptor over a 5x5 square, letters coded a=0..z=25 with j read as i.
// Build the square with key-letter transactions (repeats skipped) closed by a key-end
// transaction, then stream plaintext letters; a plaintext-end transaction pads an odd
// leftover and marks that pair with rsp_tlast. A key letter after a finished key starts
// a new square. A key end that closes a key is accepted, then the fill counter steps
// through the alphabet and places the unused letters; a key end on a finished key is
// dropped. A transaction that completes a pair passes through letter-position lookup,
// square lookup and load of the output register, and the load waits while the output
// register still holds an earlier pair. The output register lets the next transaction
// in while a pair waits on rsp_tready.
module playfair_digraph_cipher import pfc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [4:0] letter, [7:5] zero
   input  logic [1:0]  req_tuser,   // [1:0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [4:0] first_cipher, [9:5] second_cipher, [15:10] zero
   output logic        rsp_tlast    // closes_message
);

   ctrl_cmd_type  cmd;
   dp_status_type status;
   letter_type    first_cipher, second_cipher;

   pfc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   pfc_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_command (command_type'(req_tuser)),
      .req_letter  (req_tdata[4:0]),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_first   (first_cipher),
      .rsp_second  (second_cipher),
      .rsp_closes  (rsp_tlast)
   );

   assign rsp_tdata = {6'b000000, second_cipher, first_cipher};

endmodule

// ===== hw/rtl/pfc_checker.sv =====
module pfc_props import pfc_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast
);

   // no pair survives a reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a stalled pair holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // cipher letters are real square letters, never j, padding bits zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[4:0] <= LAST_LETTER) && (rsp_tdata[9:5] <= LAST_LETTER) &&
                     (rsp_tdata[4:0] != LETTER_J) && (rsp_tdata[9:5] != LETTER_J) &&
                     (rsp_tdata[15:10] == 6'd0))
      else $error("cipher letter out of the square alphabet");

   // a digraph never has equal letters, so neither does its cipher
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[4:0] != rsp_tdata[9:5]))
      else $error("cipher pair has equal letters");

endmodule

bind playfair_digraph_cipher pfc_props u_pfc_props (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

// ===== bench/pfc_checker.sv =====
// Watch both channels, predict the cipher pairs and compare them as they leave the block.
module pfc_checker import pfc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,     // [4:0] letter, [7:5] zero
   input  logic [1:0]  req_tuser,     // [1:0] command
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,     // [4:0] first_cipher, [9:5] second_cipher, [15:10] zero
   input  logic        rsp_tlast,     // closes_message
   output int          mismatches,
   output int          waiting,
   output int          pairs_checked,
   output int          pads_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      letter_type first;
      letter_type second;
      logic       closes;
   } cipher_pair_type;

   cipher_pair_type pair_queue[$];

   // shadow copy of the square and the digraph state
   letter_type grid[Cells];
   cell_type   spot[Letters];
   logic       placed[Letters];
   int         fill_at;
   logic       key_done;
   letter_type last_plain;
   logic       have_last;
   letter_type lone;
   logic       have_lone;

   // forget the plaintext stream
   task automatic drop_text();
      have_last  = 1'b0;
      last_plain = '0;
      have_lone  = 1'b0;
      lone       = '0;
   endtask

   // append a letter to the square unless it is used or the square is full
   task automatic place(input letter_type c);
      if (c <= LAST_LETTER && !placed[c] && fill_at < Cells) begin
         grid[fill_at] = c;
         spot[c]       = cell_type'(fill_at);
         placed[c]     = 1'b1;
         fill_at++;
      end
   endtask

   // apply the row, column or rectangle rule to one digraph
   function automatic cipher_pair_type encrypt(input letter_type a, input letter_type b,
                                               input logic closes);
      int pa, pb, ra, ca, rb, cb, ea, eb;
      cipher_pair_type r;
      pa = int'(spot[a]) % Cells;
      pb = int'(spot[b]) % Cells;
      ra = pa / Side;
      ca = pa % Side;
      rb = pb / Side;
      cb = pb % Side;
      if (ra == rb) begin
         ea = ra * Side + (ca + 1) % Side;
         eb = rb * Side + (cb + 1) % Side;
      end else if (ca == cb) begin
         ea = ((ra + 1) % Side) * Side + ca;
         eb = ((rb + 1) % Side) * Side + cb;
      end else begin
         ea = ra * Side + cb;
         eb = rb * Side + ca;
      end
      r.first  = grid[ea];
      r.second = grid[eb];
      r.closes = closes;
      return r;
   endfunction

   // advance the shadow state by one accepted transaction
   task automatic cipher_step(input command_type cmd, input letter_type raw);
      letter_type      c;
      letter_type      filler;
      cipher_pair_type p;
      logic            emit;
      c    = (raw == LETTER_J) ? LETTER_I : raw;
      emit = 1'b0;
      case (cmd)
         CMD_KEY_LETTER: begin
            if (c <= LAST_LETTER) begin
               // a key letter after a finished key starts a fresh square
               if (key_done) begin
                  placed   = '{default: 1'b0};
                  fill_at  = 0;
                  key_done = 1'b0;
                  drop_text();
               end
               place(c);
            end
         end
         CMD_KEY_END: begin
            if (!key_done) begin
               for (int v = 0; v < Letters; v++)
                  if (letter_type'(v) != LETTER_J) place(letter_type'(v));
               key_done = 1'b1;
               drop_text();
            end
         end
         CMD_PLAIN_LETTER: begin
            if (key_done && c <= LAST_LETTER) begin
               if (have_last && last_plain == c) begin
                  // split a doubled letter with x, or z when the letter is x
                  filler = (c == LETTER_X) ? LETTER_Z : LETTER_X;
                  if (have_lone) begin
                     p    = encrypt(lone, filler, 1'b0);
                     lone = c;
                  end else begin
                     p = encrypt(filler, c, 1'b0);
                  end
                  emit = 1'b1;
               end else if (have_lone) begin
                  p         = encrypt(lone, c, 1'b0);
                  have_lone = 1'b0;
                  emit      = 1'b1;
               end else begin
                  lone      = c;
                  have_lone = 1'b1;
               end
               last_plain = c;
               have_last  = 1'b1;
            end
         end
         default: begin
            if (key_done) begin
               // pad an odd leftover and close the message
               if (have_lone) begin
                  filler = (lone == LETTER_X) ? LETTER_Z : LETTER_X;
                  p      = encrypt(lone, filler, 1'b1);
                  emit   = 1'b1;
               end
               drop_text();
            end
         end
      endcase
      if (emit) pair_queue.push_back(p);
   endtask

   // predict on the request channel, compare on the response channel
   always @(posedge clock) begin
      cipher_pair_type want;
      if (reset) begin
         placed   = '{default: 1'b0};
         fill_at  = 0;
         key_done = 1'b0;
         drop_text();
         pair_queue.delete();
         mismatches    = 0;
         pairs_checked = 0;
         pads_checked  = 0;
      end else begin
         if (req_tvalid && req_tready)
            cipher_step(command_type'(req_tuser), req_tdata[4:0]);
         if (rsp_tvalid && rsp_tready) begin
            if (pair_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected pair first %0d second %0d last %0b",
                           $realtime, rsp_tdata[4:0], rsp_tdata[9:5], rsp_tlast);
            end else begin
               want = pair_queue.pop_front();
               pairs_checked++;
               if (want.closes) pads_checked++;
               if (rsp_tdata[4:0] !== want.first || rsp_tdata[9:5] !== want.second ||
                   rsp_tlast !== want.closes) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: pair mismatch, expected %0d %0d last %0b, got %0d %0d last %0b",
                              $realtime, want.first, want.second, want.closes,
                              rsp_tdata[4:0], rsp_tdata[9:5], rsp_tlast);
               end
            end
         end
      end
      waiting = pair_queue.size();
   end

endmodule

// ===== bench/testbench.sv =====
// Drive key and plaintext transactions into the cipher under several idle patterns.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import pfc_pkg::*;

   localparam int CycleLimit = 500000;
   localparam int Settle     = 40;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;    // [4:0] letter, [7:5] zero
   logic [1:0]  req_tuser  = '0;    // [1:0] command
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;          // [4:0] first_cipher, [9:5] second_cipher, [15:10] zero
   logic        rsp_tlast;          // closes_message

   int mismatches, waiting, pairs_checked, pads_checked;
   int send_gap_pct = 0;
   int stall_pct    = 0;
   int items_sent   = 0;
   int sessions     = 0;
   int cycles       = 0;

   playfair_digraph_cipher dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   pfc_checker scoreboard (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .mismatches    (mismatches),
      .waiting       (waiting),
      .pairs_checked (pairs_checked),
      .pads_checked  (pads_checked)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // stall the response channel at random
   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= stall_pct);

   // end the run if the block stops making progress
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CycleLimit) begin
         $display("timeout after %0d cycles, %0d pairs still expected", cycles, waiting);
         $display("** playfair_digraph_cipher: FAILED **");
         $finish;
      end
   end

   // present one transaction after a random gap and hold it until accepted
   task automatic send(input command_type cmd, input letter_type ltr);
      int gap;
      gap = 0;
      while (gap < 12 && $urandom_range(99) < send_gap_pct) gap++;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {3'b000, ltr};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   // hold the request channel idle until every expected pair has left
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (waiting != 0) @(negedge clock);
      repeat (Settle) @(negedge clock);
   endtask

   // letter code 0..25, now and then one of the unused codes above
   function automatic letter_type any_letter(input int bad_pct);
      if ($urandom_range(99) < bad_pct) return letter_type'($urandom_range(31, 26));
      return letter_type'($urandom_range(25));
   endfunction

   // one key followed by one message, with some broken or noisy transactions
   task automatic run_session();
      letter_type deck[Letters];
      letter_type tmp, ltr, prev;
      int key_len, text_len, pick, r;
      sessions++;
      if ($urandom_range(9) == 0) begin
         // whole alphabet in random order, so the square fills from the key alone
         for (int v = 0; v < Letters; v++) deck[v] = letter_type'(v);
         for (int v = Letters - 1; v > 0; v--) begin
            pick       = $urandom_range(v);
            tmp        = deck[v];
            deck[v]    = deck[pick];
            deck[pick] = tmp;
         end
         for (int v = 0; v < Letters; v++) send(CMD_KEY_LETTER, deck[v]);
         if ($urandom_range(1) == 0) send(CMD_KEY_LETTER, any_letter(10));
      end else begin
         key_len = $urandom_range(12, 1);
         for (int k = 0; k < key_len; k++) send(CMD_KEY_LETTER, any_letter(6));
      end
      send(CMD_KEY_END, any_letter(20));
      if ($urandom_range(19) == 0) send(CMD_KEY_END, any_letter(20));

      prev     = letter_type'($urandom_range(25));
      text_len = $urandom_range(40, 1);
      for (int t = 0; t < text_len; t++) begin
         r = $urandom_range(99);
         if (r < 2) begin
            // noise: any command, any code
            send(command_type'($urandom_range(3)), letter_type'($urandom_range(31)));
         end else if (r < 5) begin
            send(CMD_PLAIN_END, any_letter(30));
         end else begin
            if (r < 25)      ltr = prev;
            else if (r < 33) ltr = LETTER_X;
            else if (r < 37) ltr = LETTER_J;
            else             ltr = any_letter(6);
            send(CMD_PLAIN_LETTER, ltr);
            prev = ltr;
         end
      end
      if ($urandom_range(99) < 85) send(CMD_PLAIN_END, any_letter(30));
      if ($urandom_range(99) < 10) send(CMD_PLAIN_END, any_letter(30));
   endtask

   initial begin
      int target;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // text and end before any key: ignored
      send(CMD_PLAIN_LETTER, 5'd0);
      send(CMD_PLAIN_END, 5'd0);
      // key z, j folded to i, a repeat, an unused code, a, a repeat
      send(CMD_KEY_LETTER, LETTER_Z);
      send(CMD_KEY_LETTER, LETTER_J);
      send(CMD_KEY_LETTER, LETTER_I);
      send(CMD_KEY_LETTER, 5'd31);
      send(CMD_KEY_LETTER, 5'd0);
      send(CMD_KEY_LETTER, 5'd0);
      send(CMD_KEY_END, 5'd31);
      // second key end does nothing
      send(CMD_KEY_END, 5'd0);
      // a b: same row; d p: same column; m y: rectangle
      send(CMD_PLAIN_LETTER, 5'd0);
      send(CMD_PLAIN_LETTER, 5'd1);
      send(CMD_PLAIN_LETTER, 5'd3);
      send(CMD_PLAIN_LETTER, 5'd15);
      send(CMD_PLAIN_LETTER, 5'd12);
      send(CMD_PLAIN_LETTER, 5'd24);
      // doubled letter with nothing pending
      send(CMD_PLAIN_LETTER, 5'd24);
      // x x with x pending, then an unused code, then pad x with z
      send(CMD_PLAIN_LETTER, LETTER_X);
      send(CMD_PLAIN_LETTER, LETTER_X);
      send(CMD_PLAIN_LETTER, 5'd30);
      send(CMD_PLAIN_END, 5'd0);
      // l l, pad l with x, then an end with no leftover
      send(CMD_PLAIN_LETTER, 5'd11);
      send(CMD_PLAIN_LETTER, 5'd11);
      send(CMD_PLAIN_END, 5'd0);
      send(CMD_PLAIN_END, 5'd0);
      // unused code leaves the key alone, a real letter starts a new one
      send(CMD_KEY_LETTER, 5'd31);
      send(CMD_KEY_LETTER, 5'd4);
      drain();

      // random sessions under each idle pattern
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin
               send_gap_pct = 0;
               stall_pct    = 0;
            end
            1: begin
               send_gap_pct = 45;
               stall_pct    = 0;
            end
            2: begin
               send_gap_pct = 0;
               stall_pct    = 45;
            end
            default: begin
               send_gap_pct = 11;
               stall_pct    = 11;
            end
         endcase
         target = items_sent + 475;
         while (items_sent < target) run_session();
         drain();
      end

      $display("sent %0d transactions over %0d key and message sessions, four idle patterns",
               items_sent, sessions);
      $display("checked %0d cipher pairs, %0d of them closing padded messages",
               pairs_checked, pads_checked);
      if (mismatches == 0 && waiting == 0) begin
         $display("** playfair_digraph_cipher: PASSED **");
      end else begin
         $display("%0d mismatches, %0d pairs never arrived", mismatches, waiting);
         $display("** playfair_digraph_cipher: FAILED **");
      end
      $finish;
   end

endmodule
